[hw/rtl/cft_pkg.sv]
// Shared types, widths and constants for the complementary tilt filter.
// Used by cft_ctrl, cft_datapath and complementary_tilt_filter_top; depends on nothing.

package cft_pkg;

   localparam int IN_W       = 16;
   localparam int ANG_W      = 25;
   localparam int ALPHA_W    = 17;
   localparam int SCALE_W    = 24;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   localparam int NUM_W      = 48;   // Rounded gyro numerator after the shift by 2^11, whole digits.
   localparam int DIV_W      = 7;    // Remainder of the digit-wise divide by 125.
   localparam int DIGIT_W    = 8;    // Numerator bits consumed per divide step.
   localparam int DIVV_W     = DIV_W + DIGIT_W;
   localparam int PROD_W     = 30;   // Reciprocal product; the digit sits in its top eight bits.
   localparam int RAD_W      = 48;   // Square root radicand.
   localparam int ROOT_W     = 24;
   localparam int SREM_W     = 27;
   localparam int XW         = 45;   // CORDIC x and y.
   localparam int ZW         = 26;   // CORDIC angle.
   localparam int GW         = 40;   // Gyro-integrated angle.
   localparam int CNT_W      = 6;
   localparam int STEP_W     = 5;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 8'd1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd64225;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd128071;

   localparam logic [DIV_W:0]        DIV_CONST  = 8'd125;
   localparam logic [15:0]           DIV_RECIP  = 16'd33555;   // ceil(2^22 / 125)
   localparam logic [55:0]           GYRO_ROUND = 56'd128000;
   localparam logic signed [ZW-1:0]  DEG90      = 26'sd5898240;
   localparam logic [43:0]           ANG_POS    = 44'd16777215;
   localparam logic [43:0]           ANG_NEG    = 44'd16777216;

   localparam logic [CNT_W-1:0] DIV_LAST  = 6'(NUM_W / DIGIT_W - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = 6'(ROOT_W - 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MUL_D, ST_DIV_PREP, ST_DIV, ST_ADD_GYRO,
      ST_SQ_Y, ST_SQ_Z, ST_SQRT, ST_CR_LOAD, ST_CR_RUN, ST_CR_SAVE, ST_CP_LOAD,
      ST_CP_RUN, ST_CP_SAVE, ST_BR_MUL, ST_BR_FIN, ST_BP_MUL, ST_BP_FIN, ST_FINISH
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_MUL_C, OP_MUL_D, OP_DIV_PREP, OP_DIV_STEP,
      OP_ADD_GYRO, OP_SQ_Y, OP_SQ_Z, OP_SQRT_STEP, OP_CR_LOAD, OP_CP_LOAD, OP_CORDIC_STEP,
      OP_CR_SAVE, OP_CP_SAVE, OP_BR_MUL, OP_BR_FIN, OP_BP_MUL, OP_BP_FIN, OP_OUT_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [STEP_W-1:0]  step;
   } dp_cmd_type;

   // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] v;
      unique case (i)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/cft_ctrl.sv]
// Sequencer for the complementary tilt filter: handshakes and datapath commands.
// Depends on cft_pkg.

module cft_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cft_pkg::dp_cmd_type cmd
);

   localparam logic [cft_pkg::CNT_W-1:0] CR_LAST = cft_pkg::CNT_W'(CORDIC_STEPS - 1);

   cft_pkg::ctl_state_type state_ff, state_in;
   logic [cft_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cft_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = cft_pkg::OP_NONE;
      cmd.step     = cnt_ff[cft_pkg::STEP_W-1:0];
      unique case (state_ff)
         cft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = cft_pkg::OP_LOAD;
               state_in = cft_pkg::ST_MUL_A;
            end
         end
         cft_pkg::ST_MUL_A: begin
            cmd.op   = cft_pkg::OP_MUL_A;
            state_in = cft_pkg::ST_MUL_B;
         end
         cft_pkg::ST_MUL_B: begin
            cmd.op   = cft_pkg::OP_MUL_B;
            state_in = cft_pkg::ST_MUL_C;
         end
         cft_pkg::ST_MUL_C: begin
            cmd.op   = cft_pkg::OP_MUL_C;
            state_in = cft_pkg::ST_MUL_D;
         end
         cft_pkg::ST_MUL_D: begin
            cmd.op   = cft_pkg::OP_MUL_D;
            state_in = cft_pkg::ST_DIV_PREP;
         end
         cft_pkg::ST_DIV_PREP: begin
            cmd.op   = cft_pkg::OP_DIV_PREP;
            state_in = cft_pkg::ST_DIV;
         end
         cft_pkg::ST_DIV: begin
            cmd.op = cft_pkg::OP_DIV_STEP;
            if (cnt_ff == cft_pkg::DIV_LAST) begin
               state_in = cft_pkg::ST_ADD_GYRO;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cft_pkg::ST_ADD_GYRO: begin
            cmd.op   = cft_pkg::OP_ADD_GYRO;
            state_in = cft_pkg::ST_SQ_Y;
         end
         cft_pkg::ST_SQ_Y: begin
            cmd.op   = cft_pkg::OP_SQ_Y;
            state_in = cft_pkg::ST_SQ_Z;
         end
         cft_pkg::ST_SQ_Z: begin
            cmd.op   = cft_pkg::OP_SQ_Z;
            state_in = cft_pkg::ST_SQRT;
         end
         cft_pkg::ST_SQRT: begin
            cmd.op = cft_pkg::OP_SQRT_STEP;
            if (cnt_ff == cft_pkg::SQRT_LAST) begin
               state_in = cft_pkg::ST_CR_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cft_pkg::ST_CR_LOAD: begin
            cmd.op   = cft_pkg::OP_CR_LOAD;
            state_in = cft_pkg::ST_CR_RUN;
         end
         cft_pkg::ST_CR_RUN: begin
            cmd.op = cft_pkg::OP_CORDIC_STEP;
            if (cnt_ff == CR_LAST) begin
               state_in = cft_pkg::ST_CR_SAVE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cft_pkg::ST_CR_SAVE: begin
            cmd.op   = cft_pkg::OP_CR_SAVE;
            state_in = cft_pkg::ST_CP_LOAD;
         end
         cft_pkg::ST_CP_LOAD: begin
            cmd.op   = cft_pkg::OP_CP_LOAD;
            state_in = cft_pkg::ST_CP_RUN;
         end
         cft_pkg::ST_CP_RUN: begin
            cmd.op = cft_pkg::OP_CORDIC_STEP;
            if (cnt_ff == CR_LAST) begin
               state_in = cft_pkg::ST_CP_SAVE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cft_pkg::ST_CP_SAVE: begin
            cmd.op   = cft_pkg::OP_CP_SAVE;
            state_in = cft_pkg::ST_BR_MUL;
         end
         cft_pkg::ST_BR_MUL: begin
            cmd.op   = cft_pkg::OP_BR_MUL;
            state_in = cft_pkg::ST_BR_FIN;
         end
         cft_pkg::ST_BR_FIN: begin
            cmd.op   = cft_pkg::OP_BR_FIN;
            state_in = cft_pkg::ST_BP_MUL;
         end
         cft_pkg::ST_BP_MUL: begin
            cmd.op   = cft_pkg::OP_BP_MUL;
            state_in = cft_pkg::ST_BP_FIN;
         end
         cft_pkg::ST_BP_FIN: begin
            cmd.op   = cft_pkg::OP_BP_FIN;
            state_in = cft_pkg::ST_FINISH;
         end
         cft_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = cft_pkg::OP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = cft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cft_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/cft_datapath.sv]
// Datapath of the complementary tilt filter: gyro integration, square root,
// shared CORDIC, blend, estimates, configuration and output registers. Depends on cft_pkg.

module cft_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cft_pkg::dp_cmd_type                  cmd,
   input  logic                                 csr_valid,
   input  logic [cft_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cft_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [cft_pkg::IN_W-1:0]      req_accel_x,
   input  logic signed [cft_pkg::IN_W-1:0]      req_accel_y,
   input  logic signed [cft_pkg::IN_W-1:0]      req_accel_z,
   input  logic signed [cft_pkg::IN_W-1:0]      req_gyro_roll_rate,
   input  logic signed [cft_pkg::IN_W-1:0]      req_gyro_pitch_rate,
   input  logic [cft_pkg::IN_W-1:0]             req_elapsed_ms,
   output logic signed [cft_pkg::ANG_W-1:0]     rsp_roll_angle,
   output logic signed [cft_pkg::ANG_W-1:0]     rsp_pitch_angle
);

   logic signed [15:0] ax_ff, ay_ff, az_ff, gr_ff, gp_ff;
   logic [15:0]        ms_ff;
   logic [cft_pkg::ALPHA_W-1:0] alpha_ff;
   logic [cft_pkg::SCALE_W-1:0] scale_ff;
   logic signed [40:0] t_ff;
   logic signed [55:0] nr_ff, np_ff;
   logic [cft_pkg::NUM_W-1:0] numr_ff, nump_ff;
   logic negr_ff, negp_ff;
   logic [cft_pkg::DIV_W-1:0] remr_ff, remp_ff;
   logic signed [cft_pkg::GW-1:0] rollg_ff, pitchg_ff;
   logic [31:0] sq_ff;
   logic [cft_pkg::RAD_W-1:0]  rad_ff;
   logic [cft_pkg::SREM_W-1:0] srem_ff;
   logic [cft_pkg::ROOT_W-1:0] root_ff;
   logic signed [cft_pkg::XW-1:0] x_ff, y_ff;
   logic signed [cft_pkg::ZW-1:0] z_ff, accr_ff, accp_ff;
   logic zero_ff;
   logic signed [59:0] bl_ff;
   logic signed [cft_pkg::ANG_W-1:0] estr_ff, estp_ff, outr_ff, outp_ff;

   // Combinational helpers.
   logic signed [40:0] mul_a;
   logic signed [57:0] mul_b;
   logic [55:0] magr, magp, sumr, sump;
   logic [cft_pkg::DIV_W+cft_pkg::NUM_W-1:0] divr, divp;
   logic signed [cft_pkg::GW-1:0] qr, qp, estr_x, estp_x;
   logic signed [31:0] sq_y, sq_z;
   logic [31:0] sq_sum;
   logic [28:0] srs, strial;
   logic sge;
   logic signed [16:0] nax;
   logic signed [cft_pkg::XW-1:0] cxi, cyi, cx, cy, dx, dy;
   logic signed [cft_pkg::ZW-1:0] cz;
   logic czero;
   logic [cft_pkg::ALPHA_W-1:0] alc;
   logic signed [cft_pkg::GW-1:0] bg;
   logic signed [cft_pkg::ZW-1:0] ba;
   logic signed [40:0] bdiff;
   logic signed [58:0] bprod;
   logic signed [59:0] bsum;
   logic [59:0] bmag, brnd;
   logic [43:0] bq;
   logic signed [cft_pkg::ANG_W-1:0] bres;

   // One digit of the divide by 125. Eight numerator bits enter beside the remainder and
   // the quotient digit comes from a reciprocal multiply, exact while the partial value
   // stays below 125 * 256. Returns {remainder, shifted numerator with the new digit}.
   function automatic logic [cft_pkg::DIV_W+cft_pkg::NUM_W-1:0] div_step(
      input logic [cft_pkg::DIV_W-1:0] rem, input logic [cft_pkg::NUM_W-1:0] num);
      logic [cft_pkg::DIVV_W-1:0]  v;
      logic [cft_pkg::PROD_W-1:0]  prod;
      logic [cft_pkg::DIGIT_W-1:0] qd;
      logic [cft_pkg::DIVV_W-1:0]  back;
      v    = {rem, num[cft_pkg::NUM_W-1 -: cft_pkg::DIGIT_W]};
      prod = cft_pkg::PROD_W'(v) * cft_pkg::PROD_W'(cft_pkg::DIV_RECIP);
      qd   = prod[cft_pkg::PROD_W-1 -: cft_pkg::DIGIT_W];
      back = cft_pkg::DIVV_W'(qd) * cft_pkg::DIVV_W'(cft_pkg::DIV_CONST);
      return {cft_pkg::DIV_W'(v - back), num[cft_pkg::NUM_W-cft_pkg::DIGIT_W-1:0], qd};
   endfunction

   always_comb begin
      mul_a = (cmd.op == cft_pkg::OP_MUL_A) ? gr_ff * $signed({1'b0, scale_ff})
                                            : gp_ff * $signed({1'b0, scale_ff});
      mul_b = t_ff * $signed({1'b0, ms_ff});

      magr = nr_ff[55] ? (56'd0 - nr_ff) : nr_ff;
      magp = np_ff[55] ? (56'd0 - np_ff) : np_ff;
      sumr = magr + cft_pkg::GYRO_ROUND;
      sump = magp + cft_pkg::GYRO_ROUND;
      divr = div_step(remr_ff, numr_ff);
      divp = div_step(remp_ff, nump_ff);
      qr = {2'b00, numr_ff[37:0]};
      qp = {2'b00, nump_ff[37:0]};
      estr_x = {{15{estr_ff[24]}}, estr_ff};
      estp_x = {{15{estp_ff[24]}}, estp_ff};

      sq_y   = ay_ff * ay_ff;
      sq_z   = az_ff * az_ff;
      sq_sum = sq_ff + sq_z;
      srs    = {srem_ff, rad_ff[cft_pkg::RAD_W-1 -: 2]};
      strial = {3'b000, root_ff, 2'b01};
      sge    = (srs >= strial);

      // CORDIC start vector; a left-half-plane vector is first turned by 90 degrees.
      nax = -$signed({ax_ff[15], ax_ff});
      if (cmd.op == cft_pkg::OP_CR_LOAD) begin
         cxi   = {{13{az_ff[15]}}, az_ff, 16'd0};
         cyi   = {{13{ay_ff[15]}}, ay_ff, 16'd0};
         czero = (ay_ff == 16'sd0) && (az_ff == 16'sd0);
      end else begin
         cxi   = {5'd0, root_ff, 16'd0};
         cyi   = {{4{nax[16]}}, nax, 24'd0};
         czero = (ax_ff == 16'sd0) && (root_ff == '0);
      end
      if (cxi[cft_pkg::XW-1]) begin
         if (!cyi[cft_pkg::XW-1]) begin
            cx = cyi;
            cy = -cxi;
            cz = cft_pkg::DEG90;
         end else begin
            cx = -cyi;
            cy = cxi;
            cz = -cft_pkg::DEG90;
         end
      end else begin
         cx = cxi;
         cy = cyi;
         cz = '0;
      end
      dx = y_ff >>> cmd.step;
      dy = x_ff >>> cmd.step;

      // Blend as alpha*(g - a) + a*2^16, then round half away from zero and saturate.
      alc = (alpha_ff > cft_pkg::ALPHA_ONE) ? cft_pkg::ALPHA_ONE : alpha_ff;
      bg  = (cmd.op == cft_pkg::OP_BR_MUL) ? rollg_ff : pitchg_ff;
      ba  = (cmd.op == cft_pkg::OP_BR_MUL) ? accr_ff : accp_ff;
      bdiff = {bg[cft_pkg::GW-1], bg} - {{15{ba[cft_pkg::ZW-1]}}, ba};
      bprod = $signed({1'b0, alc}) * bdiff;
      bsum  = {bprod[58], bprod} + {{18{ba[cft_pkg::ZW-1]}}, ba, 16'd0};
      bmag  = bl_ff[59] ? (60'd0 - bl_ff) : bl_ff;
      brnd  = bmag + 60'd32768;
      bq    = brnd[59:16];
      if (!bl_ff[59]) begin
         bres = (bq > cft_pkg::ANG_POS) ? 25'sd16777215 : $signed(bq[24:0]);
      end else begin
         bres = (bq > cft_pkg::ANG_NEG) ? -25'sd16777216 : $signed(25'd0 - bq[24:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= cft_pkg::ALPHA_RESET;
         scale_ff <= cft_pkg::SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            cft_pkg::REG_ALPHA: alpha_ff <= csr_wdata[cft_pkg::ALPHA_W-1:0];
            cft_pkg::REG_SCALE: scale_ff <= csr_wdata[cft_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         estr_ff <= '0;
         estp_ff <= '0;
      end else if (cmd.op == cft_pkg::OP_BR_FIN) begin
         estr_ff <= bres;
      end else if (cmd.op == cft_pkg::OP_BP_FIN) begin
         estp_ff <= bres;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         cft_pkg::OP_LOAD: begin
            ax_ff <= req_accel_x;
            ay_ff <= req_accel_y;
            az_ff <= req_accel_z;
            gr_ff <= req_gyro_roll_rate;
            gp_ff <= req_gyro_pitch_rate;
            ms_ff <= req_elapsed_ms;
         end
         cft_pkg::OP_MUL_A, cft_pkg::OP_MUL_C: t_ff <= mul_a;
         cft_pkg::OP_MUL_B: nr_ff <= mul_b[55:0];
         cft_pkg::OP_MUL_D: np_ff <= mul_b[55:0];
         cft_pkg::OP_DIV_PREP: begin
            numr_ff <= cft_pkg::NUM_W'(sumr[54:11]);
            nump_ff <= cft_pkg::NUM_W'(sump[54:11]);
            negr_ff <= nr_ff[55];
            negp_ff <= np_ff[55];
            remr_ff <= '0;
            remp_ff <= '0;
         end
         cft_pkg::OP_DIV_STEP: begin
            {remr_ff, numr_ff} <= divr;
            {remp_ff, nump_ff} <= divp;
         end
         cft_pkg::OP_ADD_GYRO: begin
            rollg_ff  <= estr_x + (negr_ff ? -qr : qr);
            pitchg_ff <= estp_x + (negp_ff ? -qp : qp);
         end
         cft_pkg::OP_SQ_Y: sq_ff <= sq_y;
         cft_pkg::OP_SQ_Z: begin
            rad_ff  <= {sq_sum, 16'd0};
            srem_ff <= '0;
            root_ff <= '0;
         end
         cft_pkg::OP_SQRT_STEP: begin
            srem_ff <= sge ? cft_pkg::SREM_W'(srs - strial) : srs[cft_pkg::SREM_W-1:0];
            root_ff <= {root_ff[cft_pkg::ROOT_W-2:0], sge};
            rad_ff  <= {rad_ff[cft_pkg::RAD_W-3:0], 2'b00};
         end
         cft_pkg::OP_CR_LOAD, cft_pkg::OP_CP_LOAD: begin
            x_ff    <= cx;
            y_ff    <= cy;
            z_ff    <= cz;
            zero_ff <= czero;
         end
         cft_pkg::OP_CORDIC_STEP: begin
            if (!y_ff[cft_pkg::XW-1]) begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + cft_pkg::atan_entry(cmd.step);
            end else begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - cft_pkg::atan_entry(cmd.step);
            end
         end
         cft_pkg::OP_CR_SAVE: accr_ff <= zero_ff ? '0 : z_ff;
         cft_pkg::OP_CP_SAVE: accp_ff <= zero_ff ? '0 : z_ff;
         cft_pkg::OP_BR_MUL, cft_pkg::OP_BP_MUL: bl_ff <= bsum;
         cft_pkg::OP_OUT_LOAD: begin
            outr_ff <= estr_ff;
            outp_ff <= estp_ff;
         end
         default: ;
      endcase
   end

   assign rsp_roll_angle  = outr_ff;
   assign rsp_pitch_angle = outp_ff;

endmodule

[hw/rtl/complementary_tilt_filter_top.sv]
// Top level of the complementary tilt filter: sequencer plus datapath.
// Depends on cft_pkg, cft_ctrl and cft_datapath.
//
//   Channel   Direction  Handshake              Word
//   req_*     in         req_valid/req_ready    one IMU sample and elapsed time
//   rsp_*     out        rsp_valid/rsp_ready    filtered roll and pitch angles
//   csr_*     in         csr_valid/csr_ready    register index and write data
//
// A sample is finished before the next one is accepted. The divide by 125 (six eight-bit
// digits by reciprocal multiply), the bit-serial square root (24 steps) and the shared
// CORDIC unit, run once per angle, are the iterative phases of each sample.
// Reset is synchronous and active high; it restores the register defaults and zeroes
// both angle estimates. A new sample is taken while a result waits on rsp; the
// block holds its finished result until the previous word has been taken.

module complementary_tilt_filter_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cft_pkg::IN_W-1:0]    req_accel_x,
   input  logic signed [cft_pkg::IN_W-1:0]    req_accel_y,
   input  logic signed [cft_pkg::IN_W-1:0]    req_accel_z,
   input  logic signed [cft_pkg::IN_W-1:0]    req_gyro_roll_rate,
   input  logic signed [cft_pkg::IN_W-1:0]    req_gyro_pitch_rate,
   input  logic [cft_pkg::IN_W-1:0]           req_elapsed_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [cft_pkg::ANG_W-1:0]   rsp_roll_angle,
   output logic signed [cft_pkg::ANG_W-1:0]   rsp_pitch_angle,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cft_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cft_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cft_pkg::dp_cmd_type cmd;

   // Register writes are taken in any cycle; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   // The sequencer owns the handshakes and walks the datapath through its phases.
   cft_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the sample, the estimates, the registers and the result word.
   cft_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .req_gyro_roll_rate  (req_gyro_roll_rate),
      .req_gyro_pitch_rate (req_gyro_pitch_rate),
      .req_elapsed_ms      (req_elapsed_ms),
      .rsp_roll_angle      (rsp_roll_angle),
      .rsp_pitch_angle     (rsp_pitch_angle)
   );

endmodule
